// ===== sv/sparse_nonzero_tile_counter_macros.svh =====
// assertion macros shared by the tile counter rtl
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef SPARSE_NONZERO_TILE_COUNTER_MACROS_SVH
`define SPARSE_NONZERO_TILE_COUNTER_MACROS_SVH

// condition must hold at every clock edge out of reset
`define SNT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tile counter check failed");

// condition must never hold at a clock edge out of reset
`define SNT_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tile counter check failed");

// antecedent implies consequent at the following clock edge
`define SNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tile counter check failed");

`endif

// ===== sv/snt_pkg.sv =====
// shared constants and types for the sparse nonzero tile counter
// no dependencies; imported by every module of the block but the tag memory
`default_nettype none

package snt_pkg;

    // field widths of the stream
    localparam int ROW_W       = 16;
    localparam int COL_W       = 16;
    localparam int COUNT_W     = 23;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    // tag entry layout
    localparam int TAG_W   = 12;
    localparam int EPOCH_W = 8;
    localparam logic [TAG_W-1:0]   TAG_NONE  = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    // saturation point of the total
    localparam logic [COUNT_W-1:0] TOTAL_MAX = 23'd4194304;

    // result queue
    localparam int OUT_DEPTH = 4;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int CRED_W    = $clog2(OUT_DEPTH + 1);

    // parameter defaults
    localparam int TILE_DEF      = 32;
    localparam int COL_TILES_DEF = 2048;

    // one nonzero on its way to the tag memory
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [EPOCH_W-1:0] epoch;
        logic [TAG_W-1:0]   tag;
    } snt_item_t;

    // one stored tag memory entry
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [TAG_W-1:0]   tag;
    } snt_entry_t;

    // one finished total
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } snt_result_t;

endpackage

`default_nettype wire

// ===== sv/snt_slot_calc.sv =====
// index pipeline: block row tag and tag memory slot of each nonzero
// depends on snt_pkg; divisions by constants via reciprocal multiplies
`default_nettype none

module snt_slot_calc #(
    parameter int TILE      = 32,
    parameter int COL_TILES = 2048,
    parameter int AW        = 11
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [snt_pkg::ROW_W-1:0]   row,
    input  wire logic [snt_pkg::COL_W-1:0]   col,
    input  wire logic                        last,
    input  wire logic [snt_pkg::EPOCH_W-1:0] epoch,
    output snt_pkg::snt_item_t               item,
    output logic [AW-1:0]                    slot
);
    import snt_pkg::*;

    // floor(x / TILE) for 16 bit x as (x * DIV_M) >> DIV_SH
    localparam int DIV_SH = ROW_W + $clog2(TILE);
    localparam logic [63:0] DIV_M64 =
        ((64'd1 << DIV_SH) + 64'(TILE) - 64'd1) / 64'(TILE);
    localparam logic [16:0] DIV_M = DIV_M64[16:0];

    // floor(x / COL_TILES) the same way
    localparam int FOLD_SH = COL_W + $clog2(COL_TILES);
    localparam logic [63:0] FOLD_M64 =
        ((64'd1 << FOLD_SH) + 64'(COL_TILES) - 64'd1) / 64'(COL_TILES);
    localparam logic [16:0] FOLD_M = FOLD_M64[16:0];

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic                last1_reg, last2_reg, last3_reg, last4_reg;
    logic [EPOCH_W-1:0]  ep1_reg, ep2_reg, ep3_reg, ep4_reg;
    logic [ROW_W-1:0]    row1_reg;
    logic [COL_W-1:0]    col1_reg;
    logic [TAG_W-1:0]    tag2_reg, tag3_reg, tag4_reg;
    logic [COL_W-1:0]    ctile2_reg, ctile3_reg;
    logic [COL_W-1:0]    fq3_reg;
    logic [AW-1:0]       slot4_reg;

    logic [32:0]         row_prod;
    logic [32:0]         col_prod;
    logic [32:0]         fold_prod;
    logic [32:0]         back_prod;
    logic [ROW_W-1:0]    block_row;
    logic [COL_W-1:0]    col_tile;
    logic [COL_W-1:0]    fold_q;
    logic [COL_W-1:0]    slot_full;

    // stage two: divide row and column by the tile size
    assign row_prod  = {17'd0, row1_reg} * {16'd0, DIV_M};
    assign col_prod  = {17'd0, col1_reg} * {16'd0, DIV_M};
    assign block_row = ROW_W'(row_prod >> DIV_SH);
    assign col_tile  = COL_W'(col_prod >> DIV_SH);

    // stage three: quotient of the column tile by the memory depth
    assign fold_prod = {17'd0, ctile2_reg} * {16'd0, FOLD_M};
    assign fold_q    = COL_W'(fold_prod >> FOLD_SH);

    // stage four: remainder, exact in 16 bits since it is below the depth
    assign back_prod = {17'd0, fq3_reg} * 33'(COL_TILES);
    assign slot_full = ctile3_reg - back_prod[COL_W-1:0];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        row1_reg   <= row;
        col1_reg   <= col;
        last1_reg  <= last;
        ep1_reg    <= epoch;

        tag2_reg   <= block_row[TAG_W-1:0];
        ctile2_reg <= col_tile;
        last2_reg  <= last1_reg;
        ep2_reg    <= ep1_reg;

        tag3_reg   <= tag2_reg;
        ctile3_reg <= ctile2_reg;
        fq3_reg    <= fold_q;
        last3_reg  <= last2_reg;
        ep3_reg    <= ep2_reg;

        tag4_reg   <= tag3_reg;
        slot4_reg  <= slot_full[AW-1:0];
        last4_reg  <= last3_reg;
        ep4_reg    <= ep3_reg;
    end

    assign item.valid = v4_reg;
    assign item.last  = last4_reg;
    assign item.epoch = ep4_reg;
    assign item.tag   = tag4_reg;
    assign slot       = slot4_reg;

endmodule

`default_nettype wire

// ===== sv/snt_tag_ram.sv =====
// simple dual port tag memory, one write and one registered read per cycle
// no dependencies; contents undefined until written
`default_nettype none

module snt_tag_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 20
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [DW-1:0]      rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, old data on a same address collision
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/snt_tag_update.sv =====
// read-compare-write of tile owner tags, running total and clearing pass
// depends on snt_pkg and snt_tag_ram
`default_nettype none

module snt_tag_update #(
    parameter int COL_TILES = 2048,
    parameter int AW        = 11
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire snt_pkg::snt_item_t item,
    input  wire logic [AW-1:0]      slot,
    output snt_pkg::snt_result_t    result,
    output logic                    pass_done
);
    import snt_pkg::*;

    localparam int DW = EPOCH_W + TAG_W;
    localparam logic [AW-1:0] CLR_LAST = AW'(COL_TILES - 1);

    snt_item_t          upd_reg;
    logic [AW-1:0]      upd_slot_reg;
    logic [DW-1:0]      rdata;
    snt_entry_t         rd_entry;
    snt_entry_t         stored;
    logic [TAG_W-1:0]   owner_tag;
    logic               new_tile;

    logic               clr_active_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;
    logic               fwd_valid_reg;
    logic [AW-1:0]      fwd_addr_reg;
    snt_entry_t         fwd_data_reg;
    logic               res_valid_reg;
    logic [COUNT_W-1:0] res_count_reg;

    logic               we;
    logic [AW-1:0]      waddr;
    snt_entry_t         wdata;
    logic               frame_end;

    snt_tag_ram #(
        .DEPTH (COL_TILES),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (slot),
        .rdata (rdata)
    );

    // forward the previous cycle's write, the ram returned stale data for it
    assign rd_entry = rdata;
    assign stored   = (fwd_valid_reg && fwd_addr_reg == upd_slot_reg) ? fwd_data_reg
                                                                       : rd_entry;

    // an entry from an older frame counts as unowned
    assign owner_tag = (stored.epoch == upd_reg.epoch) ? stored.tag : TAG_NONE;
    assign new_tile  = upd_reg.valid && (owner_tag != upd_reg.tag);
    assign frame_end = upd_reg.valid && upd_reg.last;

    // saturating total including this nonzero
    always_comb
    begin
        total_next = total_reg;
        if (new_tile && total_reg < TOTAL_MAX)
        begin
            total_next = total_reg + 1'b1;
        end
    end

    // write port: clearing pass or tag write back
    always_comb
    begin
        we    = clr_active_reg || upd_reg.valid;
        waddr = upd_slot_reg;
        wdata = '{epoch: upd_reg.epoch, tag: upd_reg.tag};
        if (clr_active_reg)
        begin
            waddr = clr_cnt_reg;
            wdata = '{epoch: '0, tag: TAG_NONE};
        end
    end

    assign pass_done = clr_active_reg && (clr_cnt_reg == CLR_LAST);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_reg        <= '0;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            total_reg      <= '0;
            fwd_valid_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            upd_reg       <= item;
            fwd_valid_reg <= we;
            res_valid_reg <= frame_end;
            total_reg     <= frame_end ? '0 : total_next;
            if (clr_active_reg)
            begin
                if (pass_done)
                begin
                    clr_active_reg <= 1'b0;
                    clr_cnt_reg    <= '0;
                end
                else
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
            end
            else if (frame_end && upd_reg.epoch == EPOCH_MAX)
            begin
                clr_active_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        upd_slot_reg  <= slot;
        fwd_addr_reg  <= waddr;
        fwd_data_reg  <= wdata;
        res_count_reg <= total_next;
    end

    assign result.valid = res_valid_reg;
    assign result.count = res_count_reg;

endmodule

`default_nettype wire

// ===== sv/sparse_nonzero_tile_counter.sv =====
// throughput: one nonzero per cycle while s_axis_tready is high; the tag
// memory's read-compare-write with write forwarding sets that; at most 4 totals
// may be outstanding downstream
// reset: clears control state, then a clearing pass over all COL_TILES tag
// memory entries holds s_axis_tready low; the same pass follows every 256th
// frame when the frame epoch wraps
`default_nettype none

`include "sparse_nonzero_tile_counter_macros.svh"

module sparse_nonzero_tile_counter #(
    parameter int TILE      = snt_pkg::TILE_DEF,
    parameter int COL_TILES = snt_pkg::COL_TILES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // row_index [15:0], col_index [31:16]
    input  wire logic [snt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // last_nonzero
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tile_count [22:0], zero [23]
    output logic [snt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import snt_pkg::*;

    localparam int AW = (COL_TILES > 1) ? $clog2(COL_TILES) : 1;

    logic               in_acc;
    logic               out_pop;
    logic               hold_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [CRED_W-1:0]  credit_reg;
    logic [COUNT_W-1:0] fifo_mem [OUT_DEPTH];
    logic [OPTR_W-1:0]  wr_ptr_reg;
    logic [OPTR_W-1:0]  rd_ptr_reg;
    logic [CRED_W-1:0]  fifo_cnt_reg;

    snt_item_t          item;
    logic [AW-1:0]      slot;
    snt_result_t        result;
    logic               pass_done;

    // request handshakes
    assign s_axis_tready = !hold_reg && (credit_reg < CRED_W'(OUT_DEPTH));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_pop       = m_axis_tvalid && m_axis_tready;

    snt_slot_calc #(
        .TILE      (TILE),
        .COL_TILES (COL_TILES),
        .AW        (AW)
    ) u_slot_calc (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_acc),
        .row      (s_axis_tdata[ROW_W-1:0]),
        .col      (s_axis_tdata[ROW_W+COL_W-1:ROW_W]),
        .last     (s_axis_tlast),
        .epoch    (epoch_reg),
        .item     (item),
        .slot     (slot)
    );

    snt_tag_update #(
        .COL_TILES (COL_TILES),
        .AW        (AW)
    ) u_tag_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .slot      (slot),
        .result    (result),
        .pass_done (pass_done)
    );

    // frame epoch, input hold around clearing passes, result credits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= 1'b1;
            epoch_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (pass_done)
            begin
                hold_reg <= 1'b0;
            end
            else if (in_acc && s_axis_tlast && epoch_reg == EPOCH_MAX)
            begin
                hold_reg <= 1'b1;
            end
            if (in_acc && s_axis_tlast)
            begin
                epoch_reg <= epoch_reg + 1'b1;
            end
            credit_reg <= credit_reg + CRED_W'(in_acc && s_axis_tlast)
                          - CRED_W'(out_pop);
        end
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (result.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_reg + CRED_W'(result.valid) - CRED_W'(out_pop);
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            fifo_mem[wr_ptr_reg] <= result.count;
        end
    end

    assign m_axis_tvalid = (fifo_cnt_reg != '0);
    assign m_axis_tdata  = {1'b0, fifo_mem[rd_ptr_reg]};

    // checks
    `SNT_ASSERT_ALWAYS(a_credit_covers_queue, clk, rst_n, credit_reg >= fifo_cnt_reg)
    `SNT_ASSERT_NEVER(a_queue_overflow, clk, rst_n, result.valid && fifo_cnt_reg == CRED_W'(OUT_DEPTH) && !out_pop)
    `SNT_ASSERT_ALWAYS(a_total_in_range, clk, rst_n, !result.valid || result.count <= TOTAL_MAX)
    `SNT_ASSERT_NEXT(a_wrap_holds_input, clk, rst_n, in_acc && s_axis_tlast && epoch_reg == EPOCH_MAX, !s_axis_tready)

endmodule

`default_nettype wire
